// ===== hw/rtl/cdac_pkg.sv =====
package cdac_pkg;

	localparam logic [63:0] NULL_MASK = 64'h0000_1fff_fc01_8004;
	localparam logic [11:0] LOW12     = 12'h0fff;
	localparam logic [8:0]  LOW9      = 9'h1ff;
	localparam logic [13:0] MANT_MASK = 14'h3fff;
	localparam int unsigned MANT_BITS = 14;
	localparam int unsigned WIN_SHIFT = 11;
	localparam int unsigned PERM_WRITE = 8;
	localparam int unsigned PERM_READ  = 9;

	// region correction applied to the upper address part
	typedef enum logic [1:0] {
		ADJ_ZERO = 2'd0,
		ADJ_UP   = 2'd1,
		ADJ_DOWN = 2'd2
	} adj_t;

	// decoded request, as held in the queue between front and back
	typedef struct packed {
		logic [11:0] perms;
		logic [3:0]  uperms;
		logic [17:0] otype;
		logic [5:0]  exp;
		logic [13:0] tm;
		logic [13:0] bm;
		adj_t        ct;
		adj_t        cb;
		logic [63:0] upper;
		logic [63:0] start;
		logic [4:0]  nbytes;
		logic        wr;
		logic        clr;
	} item_t;

	function automatic adj_t region_adjust(input logic [2:0] a3, input logic [2:0] x3,
		input logic [2:0] r);
		logic a_lo;
		logic x_lo;
		a_lo = a3 < r;
		x_lo = x3 < r;
		if (a_lo && !x_lo) begin
			return ADJ_DOWN;
		end else if (!a_lo && x_lo) begin
			return ADJ_UP;
		end
		return ADJ_ZERO;
	endfunction

	function automatic logic [63:0] adj_addend(input adj_t a);
		logic [63:0] v;
		case (a)
			ADJ_UP:   v = 64'd1;
			ADJ_DOWN: v = '1;
			default:  v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/capability_decode_and_access_check.sv =====
// Capability bounds decode and access check.
// Input channel (in_valid / in_stall): one request per transfer, made of a
// compressed capability (cap_meta, cap_address) and an access (word_offset,
// access_bytes, is_write, clear_sticky).
// Output channel (out_valid / out_stall): one result per request, in order:
// decoded bound_base and bound_top, object type, permissions, the fault of
// this access and the sticky fault.
// Throughput: one request per cycle while out_stall is low. Path: the front
// decode writes the request queue, and the back end spends two register stages
// on bounds rebuild and then on the bounds and permission compares.
// Receiver stall: the back stages hold and the queue fills; in_stall rises
// once QUEUE_DEPTH requests are waiting and drops as soon as one leaves.
// Reset: queue emptied, no result valid, sticky fault cleared.
module capability_decode_and_access_check #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] cap_meta,
	input  logic [63:0] cap_address,
	input  logic [31:0] word_offset,
	input  logic [4:0]  access_bytes,
	input  logic        is_write,
	input  logic        clear_sticky,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] bound_base,
	output logic [63:0] bound_top,
	output logic [17:0] object_type,
	output logic [11:0] permissions,
	output logic [3:0]  user_permissions,
	output logic        access_fault,
	output logic        sticky_fault
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cdac_pkg::item_t front_item;
	cdac_pkg::item_t queue_item;
	logic            push;
	logic            pop;
	logic            pop_valid;
	logic            take_ready;
	logic [CW-1:0]   count;

	assign in_stall = count == CW'(QUEUE_DEPTH);
	assign push     = in_valid && !in_stall;
	assign pop      = pop_valid && take_ready;

	cdac_front u_front (
		.cap_meta     (cap_meta),
		.cap_address  (cap_address),
		.word_offset  (word_offset),
		.access_bytes (access_bytes),
		.is_write     (is_write),
		.clear_sticky (clear_sticky),
		.item         (front_item)
	);

	cdac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (queue_item),
		.count     (count)
	);

	cdac_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.take_valid       (pop_valid),
		.take_item        (queue_item),
		.take_ready       (take_ready),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.bound_base       (bound_base),
		.bound_top        (bound_top),
		.object_type      (object_type),
		.permissions      (permissions),
		.user_permissions (user_permissions),
		.access_fault     (access_fault),
		.sticky_fault     (sticky_fault)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(QUEUE_DEPTH))
		else $error("request queue over capacity");

	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count == $past(count) + 1'b1))
		else $error("queued request not counted");

	a_queue_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count == $past(count) - 1'b1))
		else $error("dequeued request not counted");

	a_sticky_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && access_fault) |-> sticky_fault)
		else $error("fault missing from sticky fault");

endmodule

// ===== hw/rtl/cdac_front.sv =====
module cdac_front (
	input  logic [63:0]     cap_meta,
	input  logic [63:0]     cap_address,
	input  logic [31:0]     word_offset,
	input  logic [4:0]      access_bytes,
	input  logic            is_write,
	input  logic            clear_sticky,
	output cdac_pkg::item_t item
);

	logic [63:0] meta;
	logic        ie;
	logic [8:0]  t_hi;
	logic [2:0]  t_e;
	logic [10:0] b_hi;
	logic [2:0]  b_e;
	logic [5:0]  exp;
	logic [11:0] tm_lo;
	logic [13:0] bm;
	logic        carry;
	logic [1:0]  t_top2;
	logic [13:0] tm;
	logic [6:0]  sh_win;
	logic [6:0]  sh_up;
	logic [63:0] win;
	logic [2:0]  a3;
	logic [2:0]  t3;
	logic [2:0]  b3;
	logic [2:0]  r;

	assign meta = cap_meta ^ cdac_pkg::NULL_MASK;
	assign ie   = meta[26];
	assign t_hi = meta[25:17];
	assign t_e  = meta[16:14];
	assign b_hi = meta[13:3];
	assign b_e  = meta[2:0];

	always_comb begin
		if (!ie) begin
			exp   = '0;
			tm_lo = {t_hi, t_e};
			bm    = {b_hi, b_e} & cdac_pkg::MANT_MASK;
			carry = (tm_lo & cdac_pkg::LOW12) < (bm[11:0] & cdac_pkg::LOW12);
		end else begin
			exp   = {t_e, b_e};
			tm_lo = {t_hi, 3'b000};
			bm    = {b_hi, 3'b000} & cdac_pkg::MANT_MASK;
			carry = (t_hi & cdac_pkg::LOW9) < (b_hi[8:0] & cdac_pkg::LOW9);
		end
	end

	// length msb from the exponent mode, plus carry out of the low bits
	assign t_top2 = bm[13:12] + {1'b0, carry} + {1'b0, ie};
	assign tm     = {t_top2, tm_lo};

	// shifts of 64 or more give zero
	assign sh_win = {1'b0, exp} + 7'(cdac_pkg::WIN_SHIFT);
	assign sh_up  = {1'b0, exp} + 7'(cdac_pkg::MANT_BITS);
	assign win    = cap_address >> sh_win;
	assign a3     = win[2:0];
	assign t3     = tm[13:11];
	assign b3     = bm[13:11];
	assign r      = b3 - 3'd1;

	always_comb begin
		item.perms  = meta[63:52];
		item.uperms = meta[51:48];
		item.otype  = meta[44:27];
		item.exp    = exp;
		item.tm     = tm;
		item.bm     = bm;
		item.ct     = cdac_pkg::region_adjust(a3, t3, r);
		item.cb     = cdac_pkg::region_adjust(a3, b3, r);
		item.upper  = cap_address >> sh_up;
		item.start  = cap_address + {30'd0, word_offset, 2'b00};
		item.nbytes = access_bytes;
		item.wr     = is_write;
		item.clr    = clear_sticky;
	end

endmodule

// ===== hw/rtl/cdac_queue.sv =====
module cdac_queue #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cdac_pkg::item_t            push_item,
	input  logic                       pop,
	output logic                       pop_valid,
	output cdac_pkg::item_t            pop_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cdac_pkg::item_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign pop_valid = count_q != '0;
	assign pop_item  = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/cdac_back.sv =====
module cdac_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take_valid,
	input  cdac_pkg::item_t take_item,
	output logic            take_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [63:0]     bound_base,
	output logic [63:0]     bound_top,
	output logic [17:0]     object_type,
	output logic [11:0]     permissions,
	output logic [3:0]      user_permissions,
	output logic            access_fault,
	output logic            sticky_fault
);

	logic [6:0]  sh_up;
	logic [63:0] base_c;
	logic [63:0] top_c;

	logic        valid_s1;
	logic [63:0] base_s1;
	logic [63:0] top_s1;
	logic [63:0] start_s1;
	logic [63:0] end_addr_s1;
	logic        perm_ok_s1;
	logic        clr_s1;
	logic [11:0] perms_s1;
	logic [3:0]  uperms_s1;
	logic [17:0] otype_s1;

	logic        valid_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic        fault_c;
	logic        sticky_c;
	logic        sticky_q;

	assign ready_s2   = !valid_s2 || !out_stall;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign take_ready = ready_s1;
	assign out_valid  = valid_s2;

	// rebuild bounds: corrected upper part above the mantissa, mantissa below
	assign sh_up  = {1'b0, take_item.exp} + 7'(cdac_pkg::MANT_BITS);
	assign base_c = ((take_item.upper + cdac_pkg::adj_addend(take_item.cb)) << sh_up)
		| ({50'd0, take_item.bm & cdac_pkg::MANT_MASK} << take_item.exp);
	assign top_c  = ((take_item.upper + cdac_pkg::adj_addend(take_item.ct)) << sh_up)
		| ({50'd0, take_item.tm & cdac_pkg::MANT_MASK} << take_item.exp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= take_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && take_valid) begin
			base_s1     <= base_c;
			top_s1      <= top_c;
			start_s1    <= take_item.start;
			end_addr_s1 <= take_item.start + {59'd0, take_item.nbytes};
			perm_ok_s1  <= take_item.wr ? take_item.perms[cdac_pkg::PERM_WRITE]
				: take_item.perms[cdac_pkg::PERM_READ];
			clr_s1      <= take_item.clr;
			perms_s1    <= take_item.perms;
			uperms_s1   <= take_item.uperms;
			otype_s1    <= take_item.otype;
		end
	end

	assign fault_c  = !((base_s1 <= start_s1) && (end_addr_s1 <= top_s1) && perm_ok_s1);
	// clear first, then fold in this request's fault
	assign sticky_c = (clr_s1 ? 1'b0 : sticky_q) | fault_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sticky_q <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				sticky_q <= sticky_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			bound_base       <= base_s1;
			bound_top        <= top_s1;
			object_type      <= otype_s1;
			permissions      <= perms_s1;
			user_permissions <= uperms_s1;
			access_fault     <= fault_c;
			sticky_fault     <= sticky_c;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned RANDOM_ITEMS = 730;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam logic [11:0] P_RD = 12'h1 << cdac_pkg::PERM_READ;
	localparam logic [11:0] P_WR = 12'h1 << cdac_pkg::PERM_WRITE;

	typedef struct packed {
		logic [63:0] meta;
		logic [63:0] addr;
		logic [31:0] woff;
		logic [4:0]  nbytes;
		logic        wr;
		logic        clr;
	} access_req_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] top;
		logic [17:0] otype;
		logic [11:0] perms;
		logic [3:0]  uperms;
		logic        fault;
		logic        sticky;
	} check_res_t;

	typedef struct packed {
		access_req_t q;
		logic        given;
		check_res_t  res;
	} access_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] cap_meta;
	logic [63:0] cap_address;
	logic [31:0] word_offset;
	logic [4:0]  access_bytes;
	logic        is_write;
	logic        clear_sticky;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] bound_base;
	logic [63:0] bound_top;
	logic [17:0] object_type;
	logic [11:0] permissions;
	logic [3:0]  user_permissions;
	logic        access_fault;
	logic        sticky_fault;

	check_res_t  pending_checks[$];
	access_row_t directed_rows[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned sent_count;
	bit          stim_done;
	bit          fault_acc;

	capability_decode_and_access_check dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cap_meta         (cap_meta),
		.cap_address      (cap_address),
		.word_offset      (word_offset),
		.access_bytes     (access_bytes),
		.is_write         (is_write),
		.clear_sticky     (clear_sticky),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.bound_base       (bound_base),
		.bound_top        (bound_top),
		.object_type      (object_type),
		.permissions      (permissions),
		.user_permissions (user_permissions),
		.access_fault     (access_fault),
		.sticky_fault     (sticky_fault)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] pack_meta(input logic [11:0] perms, input logic [3:0] uperms,
		input logic [2:0] spare, input logic [17:0] otype, input logic ie,
		input logic [8:0] t_hi, input logic [2:0] t_e, input logic [10:0] b_hi,
		input logic [2:0] b_e);
		return {perms, uperms, spare, otype, ie, t_hi, t_e, b_hi, b_e} ^ cdac_pkg::NULL_MASK;
	endfunction

	// unpack the exponent and the two 14-bit mantissas from unmasked metadata
	function automatic void split_bounds(input logic [63:0] m, output int unsigned e,
		output logic [13:0] tm, output logic [13:0] bm);
		logic [11:0] t12;
		logic        carry;
		logic [1:0]  top2;
		if (!m[26]) begin
			e = 0;
			t12 = m[25:14];
			bm = m[13:0];
			carry = t12 < bm[11:0];
		end else begin
			e = 32'({m[16:14], m[2:0]});
			t12 = {m[25:17], 3'b000};
			bm = {m[13:3], 3'b000};
			carry = m[25:17] < m[11:3];
		end
		top2 = bm[13:12] + {1'b0, carry} + {1'b0, m[26]};
		tm = {top2, t12};
	endfunction

	function automatic logic [63:0] region_step(input logic [2:0] a3, input logic [2:0] x3,
		input logic [2:0] r);
		if ((a3 < r) == (x3 < r))
			return 64'd0;
		return (a3 < r) ? '1 : 64'd1;
	endfunction

	task automatic predict_access(input access_req_t q, output check_res_t r);
		logic [63:0]  m;
		logic [63:0]  upper;
		logic [63:0]  first_byte;
		logic [63:0]  end_byte;
		int unsigned  e;
		logic [13:0]  tm;
		logic [13:0]  bm;
		logic [2:0]   a3;
		logic [2:0]   rr;
		logic         perm_ok;
		m = q.meta ^ cdac_pkg::NULL_MASK;
		split_bounds(m, e, tm, bm);
		a3 = 3'(q.addr >> (e + cdac_pkg::WIN_SHIFT));
		rr = bm[13:11] - 3'd1;
		upper = q.addr >> (e + cdac_pkg::MANT_BITS);
		r.top = ((upper + region_step(a3, tm[13:11], rr)) << (e + cdac_pkg::MANT_BITS))
			| (64'(tm) << e);
		r.base = ((upper + region_step(a3, bm[13:11], rr)) << (e + cdac_pkg::MANT_BITS))
			| (64'(bm) << e);
		r.otype = m[44:27];
		r.perms = m[63:52];
		r.uperms = m[51:48];
		first_byte = q.addr + 64'({q.woff, 2'b00});
		end_byte = first_byte + 64'(q.nbytes);
		perm_ok = q.wr ? r.perms[cdac_pkg::PERM_WRITE] : r.perms[cdac_pkg::PERM_READ];
		r.fault = !(r.base <= first_byte && end_byte <= r.top && perm_ok);
		if (q.clr)
			fault_acc = 1'b0;
		fault_acc = fault_acc | r.fault;
		r.sticky = fault_acc;
	endtask

	function automatic access_row_t access_row(input logic [63:0] meta, input logic [63:0] addr,
		input logic [31:0] woff, input logic [4:0] nbytes, input logic wr, input logic clr);
		access_row_t row;
		row = '0;
		row.q = '{meta: meta, addr: addr, woff: woff, nbytes: nbytes, wr: wr, clr: clr};
		return row;
	endfunction

	function automatic access_req_t random_access();
		access_req_t  q;
		logic [11:0]  perms;
		logic         ie;
		logic [5:0]   ex;
		logic [2:0]   t_e;
		logic [2:0]   b_e;
		logic [13:0]  tm;
		logic [13:0]  bm;
		logic [13:0]  win;
		int unsigned  e;
		int unsigned  kind;
		int unsigned  pick;
		kind = $urandom_range(0, 9);
		perms = 12'($urandom);
		perms[cdac_pkg::PERM_READ] = ($urandom_range(0, 3) != 0);
		perms[cdac_pkg::PERM_WRITE] = ($urandom_range(0, 3) != 0);
		ie = 1'($urandom_range(0, 1));
		t_e = 3'($urandom);
		b_e = 3'($urandom);
		if (ie) begin
			// mostly small exponents, a few at the top of the range
			pick = $urandom_range(0, 19);
			if (pick < 12)
				ex = 6'($urandom_range(0, 10));
			else if (pick < 17)
				ex = 6'($urandom_range(11, 52));
			else
				ex = 6'($urandom_range(53, 63));
			t_e = ex[5:3];
			b_e = ex[2:0];
		end
		q.meta = pack_meta(perms, 4'($urandom), 3'($urandom), 18'($urandom), ie, 9'($urandom),
			t_e, 11'($urandom), b_e);
		q.addr = {$urandom, $urandom};
		q.wr = 1'($urandom_range(0, 1));
		q.clr = ($urandom_range(0, 19) == 0);
		if ($urandom_range(0, 6) == 0)
			q.nbytes = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
		else
			q.nbytes = 5'($urandom_range(1, 16));
		q.woff = $urandom;
		if (kind == 0) begin
			q.meta = {$urandom, $urandom};
		end else begin
			split_bounds(q.meta ^ cdac_pkg::NULL_MASK, e, tm, bm);
			// place the cursor window between the decoded base and top mantissas
			if (kind <= 6 && e <= 50 && tm > bm) begin
				win = bm + 14'($urandom_range(0, int'(tm - bm) - 1));
				q.addr = (q.addr & ~(64'h3fff << e)) | (64'(win) << e);
			end
			pick = $urandom_range(0, 9);
			if (pick < 6)
				q.woff = 32'd0;
			else if (pick < 9)
				q.woff = 32'($urandom_range(0, 3));
		end
		return q;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
	endtask

	initial begin : run_control
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_checks.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : sender
		access_row_t  row;
		access_req_t  q;
		check_res_t   want;
		int unsigned  idx;
		int unsigned  total;
		int unsigned  burst;
		logic [63:0]  m_small;

		in_valid     <= 1'b0;
		cap_meta     <= '0;
		cap_address  <= '0;
		word_offset  <= '0;
		access_bytes <= '0;
		is_write     <= 1'b0;
		clear_sticky <= 1'b0;

		// all-zero capability right after reset: no permissions, empty bounds
		row = access_row(cdac_pkg::NULL_MASK, 64'h0, 32'h0, 5'd4, 1'b0, 1'b0);
		row.given = 1'b1;
		row.res = '{base: 64'h0, top: 64'h0, otype: 18'h0, perms: 12'h0, uperms: 4'h0,
			fault: 1'b1, sticky: 1'b1};
		directed_rows.push_back(row);
		// all-ones capability, largest exponent: bounds shift out entirely
		row = access_row(~cdac_pkg::NULL_MASK, 64'h0, 32'h0, 5'd1, 1'b1, 1'b1);
		row.given = 1'b1;
		row.res = '{base: 64'h0, top: 64'h0, otype: 18'h3ffff, perms: 12'hfff, uperms: 4'hf,
			fault: 1'b1, sticky: 1'b1};
		directed_rows.push_back(row);

		// small region [0x100, 0x800) within the cursor's 16K window
		m_small = pack_meta(P_RD | P_WR, 4'h5, 3'b000, 18'h00abc, 1'b0, 9'h100, 3'h0,
			11'h020, 3'h0);
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'h0, 5'd4,
			1'b0, 1'b1));
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'h1, 5'd8,
			1'b1, 1'b0));
		directed_rows.push_back(access_row(pack_meta(P_RD, 4'ha, 3'b111, 18'h15555, 1'b0,
			9'h100, 3'h0, 11'h020, 3'h0), 64'h1234_5678_9abc_0200, 32'h0, 5'd4, 1'b1, 1'b0));
		// clear and fault in the same request
		directed_rows.push_back(access_row(pack_meta(P_WR, 4'h0, 3'b000, 18'h0, 1'b0,
			9'h100, 3'h0, 11'h020, 3'h0), 64'h1234_5678_9abc_0200, 32'h0, 5'd4, 1'b0, 1'b1));
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'h0, 5'd0,
			1'b0, 1'b1));
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'h0, 5'd31,
			1'b0, 1'b0));
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'h17f, 5'd16,
			1'b1, 1'b1));
		directed_rows.push_back(access_row(m_small, 64'h1234_5678_9abc_0200, 32'hffff_ffff,
			5'd4, 1'b0, 1'b1));
		// end address wraps to zero at the top of the address space
		directed_rows.push_back(access_row(~cdac_pkg::NULL_MASK, 64'hffff_ffff_ffff_fffc, 32'h0,
			5'd4, 1'b0, 1'b1));
		// exponents at 63, 50, 53 and 10
		directed_rows.push_back(access_row(pack_meta(P_RD, 4'h3, 3'b101, 18'h2aaaa, 1'b1,
			9'h0f0, 3'h7, 11'h055, 3'h7), 64'h8000_0000_0000_0000, 32'h0, 5'd8, 1'b0, 1'b0));
		directed_rows.push_back(access_row(pack_meta(P_RD | P_WR, 4'hc, 3'b010, 18'h0f0f0,
			1'b1, 9'h1f0, 3'h6, 11'h010, 3'h2), 64'hffff_ffff_ffff_ffff, 32'h0, 5'd1, 1'b1,
			1'b1));
		directed_rows.push_back(access_row(pack_meta(P_RD | P_WR, 4'h9, 3'b000, 18'h3c3c3,
			1'b1, 9'h1f0, 3'h6, 11'h010, 3'h5), 64'h7fff_0000_0000_1234, 32'h10, 5'd2, 1'b0,
			1'b0));
		directed_rows.push_back(access_row(pack_meta(P_RD | P_WR, 4'h6, 3'b000, 18'h00001,
			1'b1, 9'h1c0, 3'h1, 11'h040, 3'h2), 64'h0000_0000_0123_4567, 32'h3, 5'd4, 1'b0,
			1'b1));
		// base pulled up: cursor in the top region, base field in region zero
		directed_rows.push_back(access_row(m_small, 64'h0000_0000_0000_3900, 32'h0, 5'd4,
			1'b0, 1'b1));
		// base and top both pulled down: cursor below R
		directed_rows.push_back(access_row(pack_meta(P_RD | P_WR, 4'h1, 3'b000, 18'h00100,
			1'b0, 9'h1c0, 3'h0, 11'h400, 3'h0), 64'h0000_0001_0000_0800, 32'h0, 5'd4, 1'b0,
			1'b0));
		// top mantissa wraps through the carry, only the top corrected
		directed_rows.push_back(access_row(pack_meta(P_RD | P_WR, 4'h2, 3'b000, 18'h00200,
			1'b0, 9'h020, 3'h0, 11'h780, 3'h0), 64'h0000_0002_0000_3000, 32'h0, 5'd4, 1'b1,
			1'b1));
		directed_rows.push_back(access_row(64'h5a5a_c3c3_0f0f_9696, 64'ha5a5_3c3c_f0f0_6969,
			32'h8000_0001, 5'd16, 1'b0, 1'b0));

		wait (arst_n);
		@(posedge clk);
		total = directed_rows.size() + RANDOM_ITEMS;
		burst = 0;
		for (idx = 0; idx < total; idx++) begin
			if (idx < directed_rows.size())
				q = directed_rows[idx].q;
			else
				q = random_access();
			if (burst == 0) begin
				in_valid <= 1'b0;
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(10, 30)) @(posedge clk);
				else
					repeat ($urandom_range(1, 6)) @(posedge clk);
				if ($urandom_range(0, 7) == 0)
					burst = $urandom_range(64, 160);
				else
					burst = $urandom_range(1, 16);
			end
			cap_meta     <= q.meta;
			cap_address  <= q.addr;
			word_offset  <= q.woff;
			access_bytes <= q.nbytes;
			is_write     <= q.wr;
			clear_sticky <= q.clr;
			in_valid     <= 1'b1;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			predict_access(q, want);
			if (idx < directed_rows.size()) begin
				if (directed_rows[idx].given)
					want = directed_rows[idx].res;
			end
			pending_checks.push_back(want);
			sent_count++;
			burst--;
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin : receiver
		int unsigned mode;
		int unsigned phase_left;
		int unsigned hold_left;
		bit          held_once;
		mode = 0;
		phase_left = 0;
		hold_left = 0;
		held_once = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			// hold off once for a long stretch so the request queue fills
			if (!held_once && sent_count >= 150) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((cycles % 5) < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		check_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_checks.size() == 0) begin
				report_mismatch("unexpected result, base", bound_base, 64'h0);
			end else begin
				want = pending_checks.pop_front();
				if (bound_base !== want.base)
					report_mismatch("bound_base", bound_base, want.base);
				if (bound_top !== want.top)
					report_mismatch("bound_top", bound_top, want.top);
				if (object_type !== want.otype)
					report_mismatch("object_type", 64'(object_type), 64'(want.otype));
				if (permissions !== want.perms)
					report_mismatch("permissions", 64'(permissions), 64'(want.perms));
				if (user_permissions !== want.uperms)
					report_mismatch("user_permissions", 64'(user_permissions), 64'(want.uperms));
				if (access_fault !== want.fault)
					report_mismatch("access_fault", 64'(access_fault), 64'(want.fault));
				if (sticky_fault !== want.sticky)
					report_mismatch("sticky_fault", 64'(sticky_fault), 64'(want.sticky));
			end
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/cdac_pkg.sv
hw/rtl/cdac_front.sv
hw/rtl/cdac_queue.sv
hw/rtl/cdac_back.sv
hw/rtl/capability_decode_and_access_check.sv
sim/testbench.sv
